@@ hw/rtl/positional_list_engine_unit_assert.svh @@
// ----------------------------------------------------------------------------
// positional_list_engine_unit assertion macros
// Immediate-cycle and next-cycle implication checks on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// ante implies cons in the same cycle
`define PLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, codes and controller/datapath structs for the list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ACT_W    = 2;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_END = 2'd0,
        ACT_DEL_END = 2'd1,
        ACT_INS_POS = 2'd2,
        ACT_DEL_POS = 2'd3
    } act_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;    // capture the incoming request
        logic    exec;    // apply the held request, load result
        op_t     op;
        logic    at_end;  // use the tail instead of the position
        status_t st;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        act_t action;
        logic full;
        logic empty;
        logic beyond;     // position past the current count
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ple_ctrl.sv @@
// ----------------------------------------------------------------------------
// ple_ctrl
// Request/result handshake state machine and action decode.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire ple_pkg::dp_stat_t stat,
    output ple_pkg::dp_cmd_t      cmd
);
    import ple_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   exec_fire;
    logic   in_fire;

    // held request retires once the result slot is free or draining
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE) || exec_fire;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire && !in_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // action decode
    always_comb
    begin
        cmd.load   = in_fire;
        cmd.exec   = exec_fire;
        cmd.op     = OP_NONE;
        cmd.at_end = 1'b1;
        cmd.st     = ST_OK;
        unique case (stat.action)
            ACT_INS_END:
            begin
                if (stat.full)
                begin
                    cmd.st = ST_FULL;
                end
                else
                begin
                    cmd.op = OP_INS;
                end
            end
            ACT_INS_POS:
            begin
                if (stat.full)
                begin
                    cmd.st = ST_FULL;
                end
                else
                begin
                    cmd.op     = OP_INS;
                    cmd.at_end = stat.beyond;
                    cmd.st     = stat.beyond ? ST_RANGE : ST_OK;
                end
            end
            ACT_DEL_END:
            begin
                if (stat.empty)
                begin
                    cmd.st = ST_EMPTY;
                end
                else
                begin
                    cmd.op = OP_DEL;
                end
            end
            ACT_DEL_POS:
            begin
                if (stat.empty)
                begin
                    cmd.st = ST_EMPTY;
                end
                else
                begin
                    cmd.op     = OP_DEL;
                    cmd.at_end = stat.beyond;
                    cmd.st     = stat.beyond ? ST_RANGE : ST_OK;
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/ple_dp.sv @@
// ----------------------------------------------------------------------------
// ple_dp
// Request register, shifting cell chain, entry count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ple_pkg::dp_cmd_t                    cmd,
    output ple_pkg::dp_stat_t                        stat,
    input  wire logic        [ple_pkg::ACT_W-1:0]    action,
    input  wire logic        [ple_pkg::POS_W-1:0]    position,
    input  wire logic signed [ple_pkg::DATA_W-1:0]   value,
    output logic             [ple_pkg::STAT_W-1:0]   status,
    output logic             [ple_pkg::COUNT_W-1:0]  count,
    output logic                                     removed_valid,
    output logic signed      [ple_pkg::DATA_W-1:0]   removed_value
);
    import ple_pkg::*;

    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    act_t                      act_reg;
    logic [POS_W-1:0]          pos_reg;
    logic signed [DATA_W-1:0]  val_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic signed [DATA_W-1:0]  cell_reg   [CAPACITY];
    logic signed [DATA_W-1:0]  cell_next  [CAPACITY];
    logic signed [DATA_W-1:0]  below_w    [CAPACITY];
    logic signed [DATA_W-1:0]  above_w    [CAPACITY];
    status_t                   status_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      rvalid_reg;
    logic signed [DATA_W-1:0]  rvalue_reg;

    logic [POS_W-1:0]          pos_eff;
    logic [POS_W-1:0]          pos_idx;
    logic [IDX_W-1:0]          end_idx;
    logic [IDX_W-1:0]          idx_sel;
    logic signed [DATA_W-1:0]  pick;

    // position zero means the head
    assign pos_eff = (pos_reg == '0) ? POS_W'(1) : pos_reg;
    assign pos_idx = pos_eff - POS_W'(1);

    assign stat.action = act_reg;
    assign stat.full   = (cnt_reg == CNT_W'(CAPACITY));
    assign stat.empty  = (cnt_reg == '0);
    assign stat.beyond = (CMP_W'(pos_eff) > CMP_W'(cnt_reg));

    // tail slot: next free cell for insert, last entry for delete
    assign end_idx = (cmd.op == OP_INS) ? IDX_W'(cnt_reg) : IDX_W'(cnt_reg - CNT_W'(1));
    assign idx_sel = cmd.at_end ? end_idx : IDX_W'(pos_idx);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= act_t'(action);
            pos_reg <= position;
            val_reg <= value;
        end
    end

    // neighbor taps of the chain; end cells see themselves
    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign below_w[k] = cell_reg[k];
            end
            else
            begin : g_below
                assign below_w[k] = cell_reg[k-1];
            end

            if (k == CAPACITY - 1)
            begin : g_tail
                assign above_w[k] = cell_reg[k];
            end
            else
            begin : g_above
                assign above_w[k] = cell_reg[k+1];
            end

            always_comb
            begin
                cell_next[k] = cell_reg[k];
                if (cmd.exec && (cmd.op == OP_INS))
                begin
                    if (IDX_W'(k) == idx_sel)
                    begin
                        cell_next[k] = val_reg;
                    end
                    else if (IDX_W'(k) > idx_sel)
                    begin
                        cell_next[k] = below_w[k];
                    end
                end
                else if (cmd.exec && (cmd.op == OP_DEL))
                begin
                    if (IDX_W'(k) >= idx_sel)
                    begin
                        cell_next[k] = above_w[k];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                cell_reg[k] <= cell_next[k];
            end
        end
    endgenerate

    // one-hot select of the removed entry
    always_comb
    begin
        pick = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            if (IDX_W'(j) == idx_sel)
            begin
                pick = pick | cell_reg[j];
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.op == OP_INS)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.op == OP_DEL)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.exec)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= cmd.st;
            count_reg  <= COUNT_W'(cnt_next);
            rvalid_reg <= (cmd.op == OP_DEL);
            rvalue_reg <= (cmd.op == OP_DEL) ? pick : '0;
        end
    end

    assign status        = status_reg;
    assign count         = count_reg;
    assign removed_valid = rvalid_reg;
    assign removed_value = rvalue_reg;

endmodule

`default_nettype wire

@@ hw/rtl/positional_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list of signed 32-bit values with end and positional
// insert/delete, kept in a chain of cells that shift in parallel.
//
//   Channel   Handshake            Payload
//   --------  -------------------  --------------------------------------------
//   request   in_valid/in_ready    action, position, value
//   result    out_valid/out_ready  status, count, removed_valid, removed_value
//
// A request transfer is captured in the request register, then applied
// to the cell chain while the result register loads; one transfer per
// cycle is sustained while results drain.
// The whole insert or delete is one parallel shift of every cell, so the
// chain update sets the cycle time, not the rate.
// Reset clears the entry count and handshake state; cell contents start
// unknown and are only read below the count.
// A stalled result holds the held request; in_ready drops until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic        [ple_pkg::ACT_W-1:0]    action,
    input  wire logic        [ple_pkg::POS_W-1:0]    position,
    input  wire logic signed [ple_pkg::DATA_W-1:0]   value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic             [ple_pkg::STAT_W-1:0]   status,
    output logic             [ple_pkg::COUNT_W-1:0]  count,
    output logic                                     removed_valid,
    output logic signed      [ple_pkg::DATA_W-1:0]   removed_value
);
    import ple_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // handshake and decode
    ple_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // cell chain, count and result register
    ple_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .position      (position),
        .value         (value),
        .status        (status),
        .count         (count),
        .removed_valid (removed_valid),
        .removed_value (removed_value)
    );

`include "positional_list_engine_unit_assert.svh"

    // an insert is never applied to a full chain
    `PLE_ASSERT_NOW(a_no_ins_full, cmd.exec && (cmd.op == OP_INS), !stat.full, "insert on full list")

    // a removal only reports ok or the tail fallback
    `PLE_ASSERT_NOW(a_rm_status, out_valid && removed_valid,
        (status == ST_OK) || (status == ST_RANGE), "removal with bad status")

    // no removal means a zero removed value
    `PLE_ASSERT_NOW(a_rm_zero, out_valid && !removed_valid, removed_value == '0,
        "nonzero removed value without removal")

    // an applied request always presents a result next cycle
    `PLE_ASSERT_NEXT(a_exec_out, cmd.exec, out_valid, "applied request without result")

endmodule

`default_nettype wire
